// ===== rtl/mp2a_pkg.sv =====
// Shared constants, register codes, helper function and the scan control
// type of the 2-D max pooling block. No dependencies.
`default_nettype none

package mp2a_pkg;

    // Defaults of the top-level size parameters
    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;
    localparam int MAX_KERNEL_DEF = 8;
    localparam int DATA_WIDTH_DEF = 16;

    // Fixed field widths
    localparam int KERN_W     = 4;  // kernel_size and stride registers
    localparam int DIM_W      = 7;  // map_rows and map_cols registers
    localparam int CHAN_W     = 9;  // channel_count register
    localparam int POS_W      = 6;  // row and column fields of a result
    localparam int CHAN_OUT_W = 8;  // channel field of a result

    // Configuration port
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    localparam logic [2:0] REG_KERNEL = 3'd0;
    localparam logic [2:0] REG_STRIDE = 3'd1;
    localparam logic [2:0] REG_ROWS   = 3'd2;
    localparam logic [2:0] REG_COLS   = 3'd3;
    localparam logic [2:0] REG_CHANS  = 3'd4;

    // Register reset values
    localparam int KERNEL_RST = 2;
    localparam int STRIDE_RST = 2;
    localparam int DIM_RST    = 64;
    localparam int CHANS_RST  = 1;

    // Bits needed to index n entries, never below one
    function automatic int cw(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // One scan step, aligned with the line-store read data
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } scan_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/mp2a_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mp2a_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  wire                                aclk,
    input  wire                                we,
    input  wire [mp2a_pkg::cw(DEPTH)-1:0]      waddr,
    input  wire [WIDTH-1:0]                    wdata,
    input  wire                                re,
    input  wire [mp2a_pkg::cw(DEPTH)-1:0]      raddr,
    output logic [WIDTH-1:0]                   rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/mp2a_seq.sv =====
// Window scan sequencer: walks the k x k window one sample per cycle and
// issues line-store reads. Depends on mp2a_pkg.
`default_nettype none

module mp2a_seq #(
    parameter int MAX_WIDTH  = mp2a_pkg::MAX_WIDTH_DEF,
    parameter int MAX_KERNEL = mp2a_pkg::MAX_KERNEL_DEF,
    localparam int KW = mp2a_pkg::cw(MAX_KERNEL),
    localparam int CW = mp2a_pkg::cw(MAX_WIDTH),
    localparam int AW = mp2a_pkg::cw(MAX_KERNEL * (2 ** CW))
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              start,
    input  wire [KW-1:0]                     start_slot,
    input  wire [mp2a_pkg::POS_W-1:0]        start_row,
    input  wire [CW-1:0]                     start_col,
    input  wire [mp2a_pkg::KERN_W-1:0]       kern,
    output logic                             rd_en,
    output logic [AW-1:0]                    rd_addr,
    output mp2a_pkg::scan_ctl_t              ctl
);

    logic                         busy_reg;
    logic [mp2a_pkg::KERN_W-1:0]  m_reg, n_reg, kern_reg;
    logic [KW-1:0]                slot_reg;
    logic [mp2a_pkg::POS_W-1:0]   row0_reg;
    logic [CW-1:0]                col0_reg;
    mp2a_pkg::scan_ctl_t          ctl_reg, ctl_next;
    logic                         last_n, last_m;
    logic [CW-1:0]                col_now;

    assign last_n  = (n_reg == kern_reg - 1'b1);
    assign last_m  = (m_reg == kern_reg - 1'b1);
    assign col_now = CW'(32'(col0_reg) + 32'(n_reg));

    assign rd_en   = busy_reg;
    assign rd_addr = AW'({slot_reg, col_now});

    always_comb begin
        ctl_next.valid = busy_reg;
        ctl_next.first = (m_reg == '0) && (n_reg == '0);
        ctl_next.last  = last_m && last_n;
        ctl_next.row   = mp2a_pkg::POS_W'(32'(row0_reg) + 32'(m_reg));
        ctl_next.col   = mp2a_pkg::POS_W'(32'(col0_reg) + 32'(n_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            ctl_reg  <= '0;
        end else begin
            ctl_reg <= ctl_next;
            if (start) begin
                busy_reg <= 1'b1;
                m_reg    <= '0;
                n_reg    <= '0;
                kern_reg <= kern;
                slot_reg <= start_slot;
                row0_reg <= start_row;
                col0_reg <= start_col;
            end else if (busy_reg) begin
                if (last_n) begin
                    // next window row: advance the ring slot
                    n_reg    <= '0;
                    m_reg    <= m_reg + 1'b1;
                    slot_reg <= (slot_reg == KW'(MAX_KERNEL - 1)) ? '0 : slot_reg + 1'b1;
                    if (last_m) begin
                        busy_reg <= 1'b0;
                    end
                end else begin
                    n_reg <= n_reg + 1'b1;
                end
            end
        end
    end

    assign ctl = ctl_reg;

endmodule

`default_nettype wire

// ===== rtl/mp2a_maxu.sv =====
// Running maximum unit: one signed compare per cycle, first element wins
// ties. Depends on mp2a_pkg.
`default_nettype none

module mp2a_maxu #(
    parameter int DATA_WIDTH = mp2a_pkg::DATA_WIDTH_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  mp2a_pkg::scan_ctl_t          ctl,
    input  wire [DATA_WIDTH-1:0]         rd_data,
    output logic [DATA_WIDTH-1:0]        best_value,
    output logic [mp2a_pkg::POS_W-1:0]   best_row,
    output logic [mp2a_pkg::POS_W-1:0]   best_col,
    output logic                         done
);

    logic [DATA_WIDTH-1:0]        best_reg;
    logic [mp2a_pkg::POS_W-1:0]   brow_reg, bcol_reg;
    logic                         done_reg;
    logic                         take;

    assign take = ctl.valid && (ctl.first || ($signed(rd_data) > $signed(best_reg)));

    always_ff @(posedge aclk) begin
        if (take) begin
            best_reg <= rd_data;
            brow_reg <= ctl.row;
            bcol_reg <= ctl.col;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= ctl.valid && ctl.last;
        end
    end

    assign best_value = best_reg;
    assign best_row   = brow_reg;
    assign best_col   = bcol_reg;
    assign done       = done_reg;

endmodule

`default_nettype wire

// ===== rtl/max_pool_2d_with_argmax_top.sv =====
// Top level of the 2-D max pooling block with argmax: stream counters,
// configuration registers and result register.
// Depends on mp2a_pkg, mp2a_ram, mp2a_seq and mp2a_maxu.
//
//   Channel   Ports                              Beat carries
//   input     s_tvalid s_tready s_tdata          one sample, raster order per channel
//   result    m_tvalid m_tready m_tdata          window maximum, argmax, position
//   config    psel penable pwrite paddr pwdata   register write / read (prdata)
//
// A sample that closes no window does not stall the input, so such beats stream at one per
// cycle. A window-closing sample holds s_tready low while the shared comparator walks
// the k x k window, k being the window side: the next beat is taken only after one
// line-store read per window sample, then read data, compare and the result load.
// Reset is synchronous and leaves the line store as it is. A result waiting on m_tready
// holds its register; the next scan runs to its end, then waits for that register to free.
`default_nettype none

module max_pool_2d_with_argmax_top #(
    parameter int MAX_WIDTH  = mp2a_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mp2a_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_KERNEL = mp2a_pkg::MAX_KERNEL_DEF,
    parameter int DATA_WIDTH = mp2a_pkg::DATA_WIDTH_DEF,
    localparam int STW = ((DATA_WIDTH + 7) / 8) * 8,
    localparam int OTW = ((DATA_WIDTH + 32 + 7) / 8) * 8
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // sample stream
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire [STW-1:0]                    s_tdata,   // sample_value
    // result stream
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // m_tdata, lowest bit up: max_value, max_row, max_col, out_row, out_col, channel
    output logic [OTW-1:0]                   m_tdata,
    // configuration
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire [mp2a_pkg::APB_AW-1:0]       paddr,
    input  wire [mp2a_pkg::APB_DW-1:0]       pwdata,
    output logic [mp2a_pkg::APB_DW-1:0]      prdata,
    output logic                             pready
);

    localparam int KW    = mp2a_pkg::cw(MAX_KERNEL);
    localparam int KSW   = KW + 1;
    localparam int CW    = mp2a_pkg::cw(MAX_WIDTH);
    localparam int RW    = mp2a_pkg::cw(MAX_HEIGHT);
    localparam int CEW   = mp2a_pkg::cw(MAX_WIDTH + MAX_KERNEL);
    localparam int REW   = mp2a_pkg::cw(MAX_HEIGHT + MAX_KERNEL);
    localparam int DEPTH = MAX_KERNEL * (2 ** CW);
    localparam int AW    = mp2a_pkg::cw(DEPTH);
    localparam int KW_F  = mp2a_pkg::KERN_W;
    localparam int DW_F  = mp2a_pkg::DIM_W;
    localparam int PW    = mp2a_pkg::POS_W;
    localparam int ROWS_RST = (MAX_HEIGHT < mp2a_pkg::DIM_RST) ? MAX_HEIGHT : mp2a_pkg::DIM_RST;
    localparam int COLS_RST = (MAX_WIDTH < mp2a_pkg::DIM_RST) ? MAX_WIDTH : mp2a_pkg::DIM_RST;
    localparam int KERN_RST = (MAX_KERNEL < mp2a_pkg::KERNEL_RST) ? MAX_KERNEL
                                                                  : mp2a_pkg::KERNEL_RST;
    localparam int STR_RST  = (MAX_KERNEL < mp2a_pkg::STRIDE_RST) ? MAX_KERNEL
                                                                  : mp2a_pkg::STRIDE_RST;

    // ---------------------------------------------------------------- config
    logic [KW_F-1:0]             kern_reg, stride_reg;
    logic [DW_F-1:0]             rows_reg, cols_reg;
    logic [mp2a_pkg::CHAN_W-1:0] chans_reg;
    logic                        cfg_we;
    logic [2:0]                  cfg_idx;
    logic                        cfg_known;
    logic [KW_F-1:0]             wr_k4;
    logic [DW_F-1:0]             wr_d7;
    logic [mp2a_pkg::CHAN_W-1:0] wr_c9;
    logic [KW_F-1:0]             kern_clamp, stride_clamp, kern_after;
    logic [DW_F-1:0]             rows_clamp, cols_clamp;
    logic [mp2a_pkg::CHAN_W-1:0] chans_clamp;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[mp2a_pkg::APB_AW-1:2];
    assign wr_k4   = pwdata[KW_F-1:0];
    assign wr_d7   = pwdata[DW_F-1:0];
    assign wr_c9   = pwdata[mp2a_pkg::CHAN_W-1:0];

    // Saturate every written value into its legal range
    assign kern_clamp   = (wr_k4 == '0) ? KW_F'(1) :
                          (32'(wr_k4) > MAX_KERNEL) ? KW_F'(MAX_KERNEL) : wr_k4;
    assign stride_clamp = kern_clamp;
    assign rows_clamp   = (wr_d7 == '0) ? DW_F'(1) :
                          (32'(wr_d7) > MAX_HEIGHT) ? DW_F'(MAX_HEIGHT) : wr_d7;
    assign cols_clamp   = (wr_d7 == '0) ? DW_F'(1) :
                          (32'(wr_d7) > MAX_WIDTH) ? DW_F'(MAX_WIDTH) : wr_d7;
    assign chans_clamp  = (wr_c9 == '0) ? mp2a_pkg::CHAN_W'(1) :
                          (32'(wr_c9) > 256) ? mp2a_pkg::CHAN_W'(256) : wr_c9;

    always_comb begin
        cfg_known  = 1'b1;
        kern_after = kern_reg;
        unique case (cfg_idx)
            mp2a_pkg::REG_KERNEL: kern_after = kern_clamp;
            mp2a_pkg::REG_STRIDE,
            mp2a_pkg::REG_ROWS,
            mp2a_pkg::REG_COLS,
            mp2a_pkg::REG_CHANS:  kern_after = kern_reg;
            default:              cfg_known  = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kern_reg   <= KW_F'(KERN_RST);
            stride_reg <= KW_F'(STR_RST);
            rows_reg   <= DW_F'(ROWS_RST);
            cols_reg   <= DW_F'(COLS_RST);
            chans_reg  <= mp2a_pkg::CHAN_W'(mp2a_pkg::CHANS_RST);
        end else if (cfg_we) begin
            unique case (cfg_idx)
                mp2a_pkg::REG_KERNEL: kern_reg   <= kern_clamp;
                mp2a_pkg::REG_STRIDE: stride_reg <= stride_clamp;
                mp2a_pkg::REG_ROWS:   rows_reg   <= rows_clamp;
                mp2a_pkg::REG_COLS:   cols_reg   <= cols_clamp;
                mp2a_pkg::REG_CHANS:  chans_reg  <= chans_clamp;
                default:              ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            mp2a_pkg::REG_KERNEL: prdata = mp2a_pkg::APB_DW'(kern_reg);
            mp2a_pkg::REG_STRIDE: prdata = mp2a_pkg::APB_DW'(stride_reg);
            mp2a_pkg::REG_ROWS:   prdata = mp2a_pkg::APB_DW'(rows_reg);
            mp2a_pkg::REG_COLS:   prdata = mp2a_pkg::APB_DW'(cols_reg);
            mp2a_pkg::REG_CHANS:  prdata = mp2a_pkg::APB_DW'(chans_reg);
            default:              prdata = '0;
        endcase
    end

    // --------------------------------------------------------- stream state
    logic [RW-1:0]                   row_reg;
    logic [CW-1:0]                   col_reg;
    logic [KW-1:0]                   ring_reg;
    logic [mp2a_pkg::CHAN_OUT_W-1:0] chan_reg;
    logic [REW-1:0]                  row_end_reg;   // bottom row of the next window row
    logic [CEW-1:0]                  col_end_reg;   // right column of the next window
    logic [RW-1:0]                   outr_reg;
    logic [CW-1:0]                   outc_reg;
    logic                            busy_reg;
    logic                            pend_reg;
    logic                            s_accept, fire, col_last, row_last, ld;
    logic [KW_F-1:0]                 km1;
    logic [KSW-1:0]                  ring_ext, km1_ext;
    logic [KW-1:0]                   slot0;
    logic [PW-1:0]                   row0;
    logic [CW-1:0]                   col0;
    logic [PW-1:0]                   hold_outr_reg, hold_outc_reg;
    logic [mp2a_pkg::CHAN_OUT_W-1:0] hold_chan_reg;

    assign s_tready = !busy_reg;
    assign s_accept = s_tvalid && s_tready;
    assign km1      = kern_reg - 1'b1;
    assign fire     = (REW'(row_reg) == row_end_reg) && (CEW'(col_reg) == col_end_reg);
    assign col_last = (32'(col_reg) + 32'd1) >= 32'(cols_reg);
    assign row_last = (32'(row_reg) + 32'd1) >= 32'(rows_reg);

    // Window origin and the ring slot holding its top row
    assign row0     = PW'(row_end_reg - REW'(km1));
    assign col0     = CW'(col_end_reg - CEW'(km1));
    assign ring_ext = {1'b0, ring_reg};
    assign km1_ext  = KSW'(km1);
    assign slot0    = (ring_ext >= km1_ext) ? KW'(ring_ext - km1_ext)
                                            : KW'(ring_ext + KSW'(MAX_KERNEL) - km1_ext);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg     <= '0;
            col_reg     <= '0;
            ring_reg    <= '0;
            chan_reg    <= '0;
            outr_reg    <= '0;
            outc_reg    <= '0;
            row_end_reg <= REW'(KERN_RST - 1);
            col_end_reg <= CEW'(KERN_RST - 1);
        end else if (cfg_we && cfg_known) begin
            // restart the stream; the line store keeps its contents
            row_reg     <= '0;
            col_reg     <= '0;
            ring_reg    <= '0;
            chan_reg    <= '0;
            outr_reg    <= '0;
            outc_reg    <= '0;
            row_end_reg <= REW'(kern_after - 1'b1);
            col_end_reg <= CEW'(kern_after - 1'b1);
        end else if (s_accept) begin
            if (col_last) begin
                col_reg     <= '0;
                outc_reg    <= '0;
                col_end_reg <= CEW'(km1);
                if (row_last) begin
                    row_reg     <= '0;
                    ring_reg    <= '0;
                    outr_reg    <= '0;
                    row_end_reg <= REW'(km1);
                    chan_reg    <= ((32'(chan_reg) + 32'd1) >= 32'(chans_reg)) ? '0
                                                                          : chan_reg + 1'b1;
                end else begin
                    row_reg  <= row_reg + 1'b1;
                    ring_reg <= (ring_reg == KW'(MAX_KERNEL - 1)) ? '0 : ring_reg + 1'b1;
                    if (REW'(row_reg) == row_end_reg) begin
                        row_end_reg <= row_end_reg + REW'(stride_reg);
                        outr_reg    <= outr_reg + 1'b1;
                    end
                end
            end else begin
                col_reg <= col_reg + 1'b1;
                if (CEW'(col_reg) == col_end_reg) begin
                    col_end_reg <= col_end_reg + CEW'(stride_reg);
                    outc_reg    <= outc_reg + 1'b1;
                end
            end
        end
    end

    // Hold the window position while the scan runs
    always_ff @(posedge aclk) begin
        if (s_accept && fire) begin
            hold_outr_reg <= PW'(outr_reg);
            hold_outc_reg <= PW'(outc_reg);
            hold_chan_reg <= chan_reg;
        end
    end

    // ------------------------------------------------- line store and scan
    logic [DATA_WIDTH-1:0] rd_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    mp2a_pkg::scan_ctl_t   scan_ctl;
    logic [DATA_WIDTH-1:0] best_value;
    logic [PW-1:0]         best_row, best_col;
    logic                  done;

    mp2a_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (s_accept),
        .waddr (AW'({ring_reg, col_reg})),
        .wdata (s_tdata[DATA_WIDTH-1:0]),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    mp2a_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (s_accept && fire),
        .start_slot (slot0),
        .start_row  (row0),
        .start_col  (col0),
        .kern       (kern_reg),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .ctl        (scan_ctl)
    );

    mp2a_maxu #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_maxu (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (scan_ctl),
        .rd_data    (rd_data),
        .best_value (best_value),
        .best_row   (best_row),
        .best_col   (best_col),
        .done       (done)
    );

    // ------------------------------------------------------ result register
    logic                            m_tvalid_reg;
    logic [DATA_WIDTH-1:0]           o_val_reg;
    logic [PW-1:0]                   o_maxr_reg, o_maxc_reg, o_outr_reg, o_outc_reg;
    logic [mp2a_pkg::CHAN_OUT_W-1:0] o_chan_reg;

    // Load the finished window once the result register is free
    assign ld = (done || pend_reg) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            pend_reg <= (done || pend_reg) && !ld;
            if (s_accept && fire) begin
                busy_reg <= 1'b1;
            end else if (ld) begin
                busy_reg <= 1'b0;
            end
            if (ld) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld) begin
            o_val_reg  <= best_value;
            o_maxr_reg <= best_row;
            o_maxc_reg <= best_col;
            o_outr_reg <= hold_outr_reg;
            o_outc_reg <= hold_outc_reg;
            o_chan_reg <= hold_chan_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OTW'({o_chan_reg, o_outc_reg, o_outr_reg,
                            o_maxc_reg, o_maxr_reg, o_val_reg});

`ifndef SYNTH
    // A window sample stalls the input from the next cycle
    a_fire_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && fire) |=> (busy_reg && !s_tready))
        else $error("window sample accepted without stalling the input");

    // The input reopens only together with a fresh result
    a_release_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        ($fell(busy_reg) && $past(aresetn)) |-> m_tvalid_reg)
        else $error("input released without a result in the output register");

    // At most one finished window waits outside the result register
    a_single_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> !pend_reg)
        else $error("scan finished while an earlier window was still pending");
`endif

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for max_pool_2d_with_argmax_top: a directed start, then random tensor
// shapes with random samples. A local pooling predictor checks every result beat.
// Depends on mp2a_pkg and the block's RTL.

module tb;
    import mp2a_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int SLOTS         = MAX_KERNEL_DEF;
    localparam int COLS_MAX      = MAX_WIDTH_DEF;
    // Longest window scan (8x8 window) with some margin
    localparam int SETTLE_CYCLES = MAX_KERNEL_DEF * MAX_KERNEL_DEF + 3 + 20;
    localparam int LIMIT_CYCLES  = 500_000;
    localparam int ITEM_TARGET   = 1250;

    // Idling profile of one phase
    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idling_t;

    // Result beat as it sits in m_tdata, lowest field at the bottom
    typedef struct packed {
        logic [CHAN_OUT_W-1:0] channel;
        logic [POS_W-1:0]      out_col;
        logic [POS_W-1:0]      out_row;
        logic [POS_W-1:0]      max_col;
        logic [POS_W-1:0]      max_row;
        logic signed [15:0]    max_value;
    } pool_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [15:0] s_tdata  = '0;     // sample_value
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [47:0] m_tdata;           // max_value, max_row, max_col, out_row, out_col, channel
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [APB_AW-1:0] paddr  = '0;
    logic [APB_DW-1:0] pwdata = '0;
    wire  [APB_DW-1:0] prdata;
    wire         pready;

    // Stimulus and expectation stores
    logic [15:0]  sample_backlog [$];
    pool_result_t window_maxima [$];

    // Predictor state
    logic signed [15:0] line_mem [SLOTS][COLS_MAX];
    int unsigned cur_row, cur_col, cur_chan, ring_slot;
    int unsigned cfg_kernel, cfg_stride, cfg_rows, cfg_cols, cfg_chans;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    logic sample_taken = 1'b0;

    int mismatch_count = 0;
    int samples_in     = 0;
    int results_out    = 0;
    int settings_used  = 0;
    int samples_queued = 0;

    max_pool_2d_with_argmax_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int unsigned clamp_to(input int unsigned v, input int unsigned lo,
                                             input int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Any write to a known register sends the stream back to the top of channel 0
    function automatic void restart_stream();
        cur_row   = 0;
        cur_col   = 0;
        cur_chan  = 0;
        ring_slot = 0;
    endfunction

    // Mirror a register write: mask to the field, then saturate to the legal range
    function automatic void apply_register(input logic [2:0] reg_idx, input logic [31:0] value);
        case (reg_idx)
            REG_KERNEL: cfg_kernel = clamp_to(value & 32'hF, 1, MAX_KERNEL_DEF);
            REG_STRIDE: cfg_stride = clamp_to(value & 32'hF, 1, MAX_KERNEL_DEF);
            REG_ROWS:   cfg_rows   = clamp_to(value & 32'h7F, 1, MAX_HEIGHT_DEF);
            REG_COLS:   cfg_cols   = clamp_to(value & 32'h7F, 1, MAX_WIDTH_DEF);
            REG_CHANS:  cfg_chans  = clamp_to(value & 32'h1FF, 1, 256);
            default:    return;
        endcase
        restart_stream();
    endfunction

    // Store one sample; if it closes a window, queue that window's maximum and argmax
    function automatic void take_sample(input logic signed [15:0] smp);
        int unsigned k, r0, c0, sl;
        logic signed [15:0] best;
        logic signed [15:0] v;
        pool_result_t res;
        k = cfg_kernel;
        line_mem[ring_slot][cur_col] = smp;
        if (cur_row + 1 >= k && cur_col + 1 >= k
                && (cur_row + 1 - k) % cfg_stride == 0
                && (cur_col + 1 - k) % cfg_stride == 0) begin
            r0 = cur_row + 1 - k;
            c0 = cur_col + 1 - k;
            best = line_mem[(ring_slot + SLOTS - (k - 1)) % SLOTS][c0];
            res.max_row = r0[POS_W-1:0];
            res.max_col = c0[POS_W-1:0];
            // Strict greater-than keeps the first element in row-major order on ties
            for (int m = 0; m < k; m++) begin
                sl = (ring_slot + SLOTS - (k - 1 - m)) % SLOTS;
                for (int n = 0; n < k; n++) begin
                    v = line_mem[sl][c0 + n];
                    if (v > best) begin
                        best = v;
                        res.max_row = 6'(r0 + m);
                        res.max_col = 6'(c0 + n);
                    end
                end
            end
            res.max_value = best;
            res.out_row   = 6'(r0 / cfg_stride);
            res.out_col   = 6'(c0 / cfg_stride);
            res.channel   = 8'(cur_chan);
            window_maxima.push_back(res);
        end
        cur_col++;
        if (cur_col >= cfg_cols) begin
            cur_col   = 0;
            ring_slot = (ring_slot + 1) % SLOTS;
            cur_row++;
            if (cur_row >= cfg_rows) begin
                cur_row   = 0;
                ring_slot = 0;
                cur_chan++;
                if (cur_chan >= cfg_chans) cur_chan = 0;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        // Cap the log; the count still grows
        if (mismatch_count <= 40) $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    task automatic check_window(input pool_result_t got);
        pool_result_t want;
        if (window_maxima.size() == 0) begin
            report_mismatch($sformatf("result beat %h with nothing expected", got));
            return;
        end
        want = window_maxima.pop_front();
        if (got.max_value !== want.max_value)
            report_mismatch($sformatf("max_value %0d, expected %0d (out %0d,%0d ch %0d)",
                got.max_value, want.max_value, want.out_row, want.out_col, want.channel));
        if (got.max_row !== want.max_row)
            report_mismatch($sformatf("max_row %0d, expected %0d", got.max_row, want.max_row));
        if (got.max_col !== want.max_col)
            report_mismatch($sformatf("max_col %0d, expected %0d", got.max_col, want.max_col));
        if (got.out_row !== want.out_row)
            report_mismatch($sformatf("out_row %0d, expected %0d", got.out_row, want.out_row));
        if (got.out_col !== want.out_col)
            report_mismatch($sformatf("out_col %0d, expected %0d", got.out_col, want.out_col));
        if (got.channel !== want.channel)
            report_mismatch($sformatf("channel %0d, expected %0d", got.channel, want.channel));
    endtask

    // Sample both channels at the rising edge; check results before predicting,
    // since a beat taken at this edge cannot yet have its result out
    always @(posedge aclk) begin
        sample_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                check_window(pool_result_t'(m_tdata));
                results_out++;
            end
            if (s_tvalid && s_tready) begin
                take_sample(s_tdata);
                samples_in++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver and receiver, both at the falling edge
    // ------------------------------------------------------------------
    // Advance to the next sample once the current beat has gone; hold it otherwise
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || sample_taken) begin
            if (sample_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_tdata  <= sample_backlog.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Stall the result channel at random
    always @(negedge aclk) begin
        m_tready <= aresetn && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic set_idling(input idling_t mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 77; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 77; end
            default:   begin send_idle_pct = 28; recv_stall_pct = 28; end
        endcase
    endtask

    // Setup cycle then access cycle; the write lands at the edge inside the access cycle
    task automatic apb_write(input logic [2:0] reg_idx, input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        apply_register(reg_idx, value);
    endtask

    // Sometimes set bits above the register field; the block must drop them
    function automatic logic [31:0] with_junk(input int unsigned v, input int w);
        logic [31:0] junk;
        junk = $urandom() << w;
        return ($urandom_range(0, 3) == 0) ? (v | junk) : v;
    endfunction

    task automatic configure(input int unsigned k, input int unsigned s,
                             input int unsigned rows, input int unsigned cols,
                             input int unsigned chans);
        apb_write(REG_KERNEL, with_junk(k, KERN_W));
        apb_write(REG_STRIDE, with_junk(s, KERN_W));
        apb_write(REG_ROWS,   with_junk(rows, DIM_W));
        apb_write(REG_COLS,   with_junk(cols, DIM_W));
        apb_write(REG_CHANS,  with_junk(chans, CHAN_W));
        settings_used++;
    endtask

    // Half full-range values, the rest a near-zero band to force ties and the extremes
    function automatic logic [15:0] pick_sample();
        int unsigned sel;
        logic signed [15:0] t;
        sel = $urandom_range(0, 9);
        if (sel < 5) return 16'($urandom_range(0, 65535));
        if (sel < 8) begin
            t = 16'($urandom_range(0, 4));
            return t - 16'sd2;
        end
        return (sel == 8) ? 16'h7FFF : 16'h8000;
    endfunction

    task automatic queue_random(input int n);
        repeat (n) sample_backlog.push_back(pick_sample());
        samples_queued += n;
    endtask

    // Wait until every sample has gone and every expected beat has come,
    // then let any scan still in flight finish
    task automatic wait_until_quiet();
        do @(negedge aclk);
        while (samples_in != samples_queued || window_maxima.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        logic [15:0] ties_and_extremes [16];
        int unsigned k, s, rows, cols, chans;
        int phase_no;

        ties_and_extremes = '{
            // channel 0: max in first cell with a later tie, then an all-zero window
            16'h7FFF, 16'h8000, 16'h0000, 16'h0000,
            16'hFFFF, 16'h7FFF, 16'h0000, 16'h0000,
            // channel 1: all-minimum window, then two equal maxima on different rows
            16'h8000, 16'h8000, 16'hFFFB, 16'hFFF9,
            16'h8000, 16'h8000, 16'hFFF9, 16'hFFFB
        };

        cfg_kernel = KERNEL_RST;
        cfg_stride = STRIDE_RST;
        cfg_rows   = DIM_RST;
        cfg_cols   = DIM_RST;
        cfg_chans  = CHANS_RST;
        restart_stream();

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset values: 2x2 windows, stride 2, 64x64 map, one channel
        set_idling(IDLE_NONE);
        settings_used++;
        queue_random(140);
        wait_until_quiet();

        // Directed: ties, extremes, channel index, then a kernel bigger than the map
        configure(2, 2, 2, 4, 2);
        foreach (ties_and_extremes[i]) sample_backlog.push_back(ties_and_extremes[i]);
        samples_queued += 16;
        wait_until_quiet();
        configure(3, 1, 2, 2, 1);
        sample_backlog.push_back(16'h7FFF);
        sample_backlog.push_back(16'h8000);
        sample_backlog.push_back(16'h0001);
        sample_backlog.push_back(16'hFFFE);
        samples_queued += 4;
        wait_until_quiet();

        // One-sample maps over 256 channels, running past the wrap back to channel 0
        configure(1, 1, 1, 1, 256);
        queue_random(260);
        wait_until_quiet();

        // Tall single-column map, reaching row 63
        set_idling(IDLE_SEND);
        configure(1, 1, 64, 1, 2);
        queue_random(130);
        wait_until_quiet();

        // Out-of-range writes: kernel and stride 0, rows 0, cols 127, channels 511
        set_idling(IDLE_RECV);
        configure(0, 0, 0, 127, 511);
        queue_random(70);
        wait_until_quiet();

        // Largest window and stride, written as 15 to saturate
        set_idling(IDLE_BOTH);
        configure(15, 15, 8, 24, 1);
        queue_random(192);
        wait_until_quiet();

        // Largest window sliding by one
        set_idling(IDLE_NONE);
        configure(8, 1, 9, 10, 1);
        queue_random(90);
        wait_until_quiet();

        // Random shapes, mostly small; a few out-of-range or oversized values
        phase_no = 0;
        while (samples_queued < ITEM_TARGET) begin
            set_idling(idling_t'(phase_no % 4));
            k = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
            s = $urandom_range(1, (k < 8) ? k + 1 : 8);
            rows  = $urandom_range(1, 12);
            cols  = $urandom_range(1, 12);
            chans = $urandom_range(1, 3);
            if ($urandom_range(0, 7) == 0) k = $urandom_range(0, 15);
            if ($urandom_range(0, 7) == 0) s = $urandom_range(0, 15);
            if ($urandom_range(0, 9) == 0) cols = $urandom_range(13, 127);
            if ($urandom_range(0, 9) == 0) rows = $urandom_range(0, 20);
            configure(k, s, rows, cols, chans);
            queue_random($urandom_range(30, 90));
            wait_until_quiet();
            phase_no++;
        end

        while (window_maxima.size() != 0) begin
            report_mismatch($sformatf("expected result never came (out %0d,%0d ch %0d)",
                window_maxima[0].out_row, window_maxima[0].out_col, window_maxima[0].channel));
            void'(window_maxima.pop_front());
        end

        $display("Run covered %0d sample beats and %0d result beats across %0d pooling shapes,",
                 samples_in, results_out, settings_used);
        $display("with idle and stall phases on both channels; %0d mismatches.", mismatch_count);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("Timeout after %0d cycles", LIMIT_CYCLES);
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mp2a_pkg.sv
rtl/mp2a_ram.sv
rtl/mp2a_seq.sv
rtl/mp2a_maxu.sv
rtl/max_pool_2d_with_argmax_top.sv
verif/tb.sv
